### rtl/tfe_pkg.sv
// shared types, format codes and channel expansion functions for the texel format expander
package tfe_pkg;

   localparam logic [2:0] FMT_RGB888   = 3'd0;
   localparam logic [2:0] FMT_RGBA8888 = 3'd1;
   localparam logic [2:0] FMT_RGBA5551 = 3'd2;
   localparam logic [2:0] FMT_RGBA4444 = 3'd3;
   localparam logic [2:0] FMT_RGB565   = 3'd4;

   // 255/31 and 255/63 folded with reciprocals of 31 (2^18) and 63 (2^20)
   localparam logic [25:0] EXP5_MUL   = 26'd2156535;
   localparam int          EXP5_SHIFT = 18;
   localparam logic [28:0] EXP6_MUL   = 29'd4244475;
   localparam int          EXP6_SHIFT = 20;

   // completed pixel waiting for expansion
   typedef struct packed {
      logic       valid;
      logic [2:0] fmt;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] last;
   } pixel_type;

   // red sits in the lowest byte
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgba_type;

   function automatic logic [2:0] pixel_length(input logic [2:0] fmt);
      logic [2:0] len;
      case (fmt)
         FMT_RGB888:   len = 3'd3;
         FMT_RGBA8888: len = 3'd4;
         FMT_RGBA5551: len = 3'd2;
         FMT_RGBA4444: len = 3'd2;
         FMT_RGB565:   len = 3'd2;
         default:      len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] exp5(input logic [4:0] x);
      logic [25:0] prod;
      prod = 26'(x) * EXP5_MUL;
      return 8'(prod >> EXP5_SHIFT);
   endfunction

   function automatic logic [7:0] exp6(input logic [5:0] x);
      logic [28:0] prod;
      prod = 29'(x) * EXP6_MUL;
      return 8'(prod >> EXP6_SHIFT);
   endfunction

   function automatic logic [7:0] exp4(input logic [3:0] x);
      return {x, x};
   endfunction

endpackage

### rtl/tfe_assembler.sv
// collects texel bytes into whole pixels and holds a completed pixel for expansion
module tfe_assembler (
   input  logic              clock,
   input  logic              reset,
   input  logic [2:0]        fmt,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              start_image,
   input  logic              advance,
   output tfe_pkg::pixel_type pixel
);
   import tfe_pkg::*;

   logic [1:0]  phase_ff, phase_in;
   logic [23:0] held_ff, held_in;
   pixel_type   pixel_ff, pixel_in;
   logic [1:0]  phase_eff;
   logic [2:0]  len;
   logic        complete;

   always_comb begin
      phase_eff = start_image ? 2'd0 : phase_ff;
      len       = pixel_length(fmt);
      complete  = (len != 3'd0) && (({1'b0, phase_eff} + 3'd1) >= len);

      phase_in = phase_ff;
      held_in  = held_ff;
      pixel_in = pixel_ff;
      if (advance) begin
         pixel_in.valid = 1'b0;
      end
      if (accept) begin
         if (len == 3'd0 || complete) begin
            phase_in = 2'd0;
         end else begin
            phase_in = phase_eff + 2'd1;
            case (phase_eff)
               2'd0:    held_in[7:0]   = data_byte;
               2'd1:    held_in[15:8]  = data_byte;
               2'd2:    held_in[23:16] = data_byte;
               default: held_in        = held_ff;
            endcase
         end
         if (complete) begin
            pixel_in.valid = 1'b1;
            pixel_in.fmt   = fmt;
            pixel_in.b0    = held_ff[7:0];
            pixel_in.b1    = held_ff[15:8];
            pixel_in.b2    = held_ff[23:16];
            pixel_in.last  = data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= 2'd0;
         held_ff        <= 24'd0;
         pixel_ff.valid <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         held_ff        <= held_in;
         pixel_ff.valid <= pixel_in.valid;
      end
      pixel_ff.fmt  <= pixel_in.fmt;
      pixel_ff.b0   <= pixel_in.b0;
      pixel_ff.b1   <= pixel_in.b1;
      pixel_ff.b2   <= pixel_in.b2;
      pixel_ff.last <= pixel_in.last;
   end

   assign pixel = pixel_ff;

endmodule

### rtl/tfe_expander.sv
// expands one assembled pixel into 8-bit rgba channels
module tfe_expander (
   input  tfe_pkg::pixel_type pixel,
   output tfe_pkg::rgba_type  rgba
);
   import tfe_pkg::*;

   logic [15:0] p;

   always_comb begin
      p = {pixel.last, pixel.b0};
      case (pixel.fmt)
         FMT_RGB888: begin
            rgba.red   = pixel.b0;
            rgba.green = pixel.b1;
            rgba.blue  = pixel.last;
            rgba.alpha = 8'hff;
         end
         FMT_RGBA8888: begin
            rgba.red   = pixel.b0;
            rgba.green = pixel.b1;
            rgba.blue  = pixel.b2;
            rgba.alpha = pixel.last;
         end
         FMT_RGBA5551: begin
            rgba.red   = exp5(p[15:11]);
            rgba.green = exp5(p[10:6]);
            rgba.blue  = exp5(p[5:1]);
            rgba.alpha = p[0] ? 8'hff : 8'h00;
         end
         FMT_RGBA4444: begin
            rgba.red   = exp4(p[15:12]);
            rgba.green = exp4(p[11:8]);
            rgba.blue  = exp4(p[7:4]);
            rgba.alpha = exp4(p[3:0]);
         end
         default: begin
            rgba.red   = exp5(p[15:11]);
            rgba.green = exp6(p[10:5]);
            rgba.blue  = exp5(p[4:0]);
            rgba.alpha = 8'hff;
         end
      endcase
   end

endmodule

### rtl/texel_format_expander_core.sv
// top level of the texel format expander: format register, pixel assembly, expansion, output
//
// usage:
//   req channel: one raw texel byte per request in req_tdata, req_tuser set on the first
//   byte of a new pixel stream (drops any partial pixel). rsp channel: one rgba8888 pixel
//   per completed input pixel (3, 4 or 2 bytes by format).
//   csr channel: writes pixel_format (0 rgb888, 1 rgba8888, 2 rgba5551, 3 rgba4444,
//   4 rgb565; other codes emit nothing). always ready; write only while idle.
// timing:
//   one request per cycle sustained while rsp_tready stays high. the pixel reaches rsp
//   through the assembly register and then the output register.
//   when rsp_tready is low one finished pixel can wait in the assembly register behind
//   the output register; req_tready drops only once both are full.
// reset:
//   synchronous, clears byte phase, held bytes, format (rgb888) and both valid flags.
module texel_format_expander_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] start_image
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_data     // [2:0] pixel_format
);
   import tfe_pkg::*;

   logic [2:0] fmt_ff, fmt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rgba_type   rsp_data_ff, rsp_data_in;
   pixel_type  pixel;
   rgba_type   rgba;
   logic       advance;
   logic       accept;

   assign csr_ready = 1'b1;
   assign advance   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !pixel.valid || advance;
   assign accept    = req_tvalid && req_tready;

   tfe_assembler u_assembler (
      .clock       (clock),
      .reset       (reset),
      .fmt         (fmt_ff),
      .accept      (accept),
      .data_byte   (req_tdata),
      .start_image (req_tuser),
      .advance     (advance),
      .pixel       (pixel)
   );

   tfe_expander u_expander (
      .pixel (pixel),
      .rgba  (rgba)
   );

   always_comb begin
      fmt_in       = (csr_valid && csr_ready) ? csr_data : fmt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = pixel.valid;
         rsp_data_in  = rgba;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= FMT_RGB888;
         rsp_valid_ff <= 1'b0;
      end else begin
         fmt_ff       <= fmt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // an empty output register always lets requests in
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output register");

   // a new response only comes from a pixel held in the assembly register
   a_rsp_from_pixel: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(pixel.valid))
      else $error("response without assembled pixel");

   // unused format codes never complete a pixel
   a_unused_format: assert property (@(posedge clock) disable iff (reset)
      accept && (fmt_ff > FMT_RGB565) && !pixel.valid |=> !pixel.valid)
      else $error("pixel completed under unused format code");
`endif

endmodule
